>>> hw/rtl/fltw_pkg.sv
// Shared types and constants for the four-level page table walker.
// No dependencies; imported by every walker module and the checker.
`default_nettype none

package fltw_pkg;

    localparam int unsigned ADDR_W      = 52;
    localparam int unsigned DATA_W      = 64;
    localparam int unsigned INDEX_W     = 9;
    localparam int unsigned IDX_BITS_W  = 36;
    localparam int unsigned CFG_IDX_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROOT   = 8'd1;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_ENTRY   = 1'b1;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    localparam logic [1:0] LEVEL_TOP  = 2'd3;
    localparam logic [1:0] LEVEL_DIR  = 2'd2;
    localparam logic [1:0] LEVEL_MID  = 2'd1;
    localparam logic [1:0] LEVEL_LEAF = 2'd0;

    localparam int unsigned BIT_PRESENT = 0;
    localparam int unsigned BIT_LARGE   = 7;

    typedef enum logic [1:0] {
        ST_MAPPED     = 2'd0,
        ST_UNMAPPED   = 2'd1,
        ST_FAULT      = 2'd2,
        ST_UNEXPECTED = 2'd3
    } fltw_status_t;

    typedef struct packed {
        logic              cmd;
        logic [DATA_W-1:0] virt_addr;
        logic [DATA_W-1:0] pte;
    } fltw_item_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] read_addr;
        fltw_status_t      status;
        logic [ADDR_W-1:0] phys_addr;
    } fltw_result_t;

    typedef struct packed {
        logic              walker_enable;
        logic [ADDR_W-1:0] root_table_base;
    } fltw_cfg_t;

    function automatic logic [INDEX_W-1:0] level_index(
        input logic [IDX_BITS_W-1:0] bits,
        input logic [1:0]            level
    );
        logic [INDEX_W-1:0] idx;
        begin
            case (level)
                LEVEL_TOP: idx = bits[35:27];
                LEVEL_DIR: idx = bits[26:18];
                LEVEL_MID: idx = bits[17:9];
                default:   idx = bits[8:0];
            endcase
            return idx;
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fltw_cfg_regs.sv
// Configuration registers of the walker: enable and root table base.
// Depends on fltw_pkg.
`default_nettype none

module fltw_cfg_regs
    import fltw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data,
    output fltw_cfg_t                 cfg
);

    logic              enable_reg;
    logic [ADDR_W-1:0] root_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            root_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IDX_ENABLE: enable_reg <= cfg_data[0];
                CFG_IDX_ROOT:   root_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.walker_enable   = enable_reg;
    assign cfg.root_table_base = root_reg;

endmodule

`default_nettype wire

>>> hw/rtl/fltw_in_stage.sv
// Input register of the walker: holds one transfer until the walk step takes it.
// Depends on fltw_pkg.
`default_nettype none

module fltw_in_stage
    import fltw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire fltw_item_t s_item,
    input  wire logic       advance,
    output logic            item_valid,
    output fltw_item_t      item
);

    logic       valid_reg;
    fltw_item_t item_reg;

    assign s_ready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

>>> hw/rtl/fltw_walk_core.sv
// Walk state and the single-pass step that turns one item into one result.
// Depends on fltw_pkg.
`default_nettype none

module fltw_walk_core
    import fltw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire fltw_cfg_t  cfg,
    input  wire fltw_item_t item,
    input  wire logic       advance,
    output fltw_result_t    result
);

    logic                  active_reg, active_next;
    logic [1:0]            level_reg, level_next;
    logic [IDX_BITS_W-1:0] index_reg, index_next;

    logic [DATA_W-1:0]     va;
    logic [DATA_W-1:0]     entry;
    logic                  addr_ok;
    logic [1:0]            level_dn;

    assign va       = item.virt_addr;
    assign entry    = item.pte;
    assign addr_ok  = (va[11:0] == 12'd0) && (va[63:48] == {16{va[47]}});
    assign level_dn = level_reg - 2'd1;

    always_comb begin
        active_next      = active_reg;
        level_next       = level_reg;
        index_next       = index_reg;
        result.kind      = KIND_FINAL;
        result.read_addr = '0;
        result.status    = ST_UNEXPECTED;
        result.phys_addr = '0;
        if (item.cmd == CMD_REQUEST) begin
            if (active_reg) begin
                result.status = ST_UNEXPECTED;
            end else if (!cfg.walker_enable || !addr_ok) begin
                result.status = ST_FAULT;
            end else begin
                index_next       = va[47:12];
                level_next       = LEVEL_TOP;
                active_next      = 1'b1;
                result.kind      = KIND_READ;
                result.status    = ST_MAPPED;
                result.read_addr = {cfg.root_table_base[51:12], va[47:39], 3'b000};
            end
        end else if (!active_reg) begin
            result.status = ST_UNEXPECTED;
        end else if (!entry[BIT_PRESENT]) begin
            active_next   = 1'b0;
            level_next    = LEVEL_TOP;
            result.status = (entry == '0) ? ST_UNMAPPED : ST_FAULT;
        end else if ((level_reg == LEVEL_DIR || level_reg == LEVEL_MID)
                     && entry[BIT_LARGE]) begin
            active_next   = 1'b0;
            level_next    = LEVEL_TOP;
            result.status = ST_FAULT;
        end else if (level_reg == LEVEL_LEAF) begin
            active_next      = 1'b0;
            level_next       = LEVEL_TOP;
            result.status    = ST_MAPPED;
            result.phys_addr = {entry[51:12], 12'd0};
        end else begin
            level_next       = level_dn;
            result.kind      = KIND_READ;
            result.status    = ST_MAPPED;
            result.read_addr = {entry[51:12], level_index(index_reg, level_dn), 3'b000};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            level_reg  <= LEVEL_TOP;
            index_reg  <= '0;
        end else if (advance) begin
            active_reg <= active_next;
            level_reg  <= level_next;
            index_reg  <= index_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/fltw_out_stage.sv
// Result register of the walker: holds a result until the consumer takes the transfer.
// Depends on fltw_pkg.
`default_nettype none

module fltw_out_stage
    import fltw_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         item_valid,
    input  wire fltw_result_t result,
    output logic              advance,
    output logic              m_valid,
    input  wire logic         m_ready,
    output fltw_result_t      m_result
);

    logic         valid_reg;
    fltw_result_t result_reg;

    assign advance = item_valid && (!valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_ready) begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

>>> hw/rtl/four_level_page_table_walker.sv
// Four-level page table walker, 4 KiB pages, 48-bit canonical virtual addresses.
// Each transfer (a translate request or a returned table entry) yields exactly one
// result: a table read request or a final status. One item is taken every cycle
// unless a full result register is not taken, which stalls the input. The input
// register feeds the result register through one combinational pass of the whole
// walk step. Configuration writes are always ready.
`default_nettype none

module four_level_page_table_walker
    import fltw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_cmd,
    input  wire logic [DATA_W-1:0]    s_virt_addr,
    input  wire logic [DATA_W-1:0]    s_pte,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_kind,
    output logic [ADDR_W-1:0]         m_read_addr,
    output logic [1:0]                m_status,
    output logic [ADDR_W-1:0]         m_phys_addr
);

    fltw_cfg_t    cfg;
    fltw_item_t   s_item;
    fltw_item_t   item;
    logic         item_valid;
    logic         advance;
    fltw_result_t result;
    fltw_result_t m_result;

    assign s_item.cmd       = s_cmd;
    assign s_item.virt_addr = s_virt_addr;
    assign s_item.pte       = s_pte;

    fltw_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fltw_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    fltw_walk_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item),
        .advance (advance),
        .result  (result)
    );

    fltw_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

    assign m_kind      = m_result.kind;
    assign m_read_addr = m_result.read_addr;
    assign m_status    = m_result.status;
    assign m_phys_addr = m_result.phys_addr;

endmodule

`default_nettype wire

>>> hw/rtl/fltw_checker.sv
// Port-level checks on the walker result channel, bound to the top level.
// Depends on fltw_pkg and four_level_page_table_walker.
`default_nettype none

module fltw_checker
    import fltw_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic              m_kind,
    input wire logic [ADDR_W-1:0] m_read_addr,
    input wire logic [1:0]        m_status,
    input wire logic [ADDR_W-1:0] m_phys_addr
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_read_addr)
            && $stable(m_status) && $stable(m_phys_addr))
        else $error("result changed while stalled");

    a_read_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_READ |-> m_status == ST_MAPPED && m_phys_addr == '0
            && m_read_addr[2:0] == 3'b000)
        else $error("malformed read request");

    a_final_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_FINAL |-> m_read_addr == '0 && m_phys_addr[11:0] == 12'd0)
        else $error("malformed final result");

    a_phys_only_mapped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_FINAL && m_status != ST_MAPPED |-> m_phys_addr == '0)
        else $error("frame address on unmapped result");

endmodule

bind four_level_page_table_walker fltw_checker u_fltw_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_kind      (m_kind),
    .m_read_addr (m_read_addr),
    .m_status    (m_status),
    .m_phys_addr (m_phys_addr)
);

`default_nettype wire

>>> tb/fltw_translation_checker.sv
`timescale 1ns / 1ps
// Checker for the four-level page table walker: tracks walk state and registers,
// predicts one result per accepted transfer and compares results in order.
// Depends on fltw_pkg for field widths, codes and the result struct.

module fltw_translation_checker
    import fltw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [DATA_W-1:0]    s_virt_addr,
    input  logic [DATA_W-1:0]    s_pte,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_kind,
    input  logic [ADDR_W-1:0]    m_read_addr,
    input  logic [1:0]           m_status,
    input  logic [ADDR_W-1:0]    m_phys_addr,
    output int                   mismatch_count,
    output int                   results_due
);

    logic                  walking;
    logic [1:0]            walk_lvl;
    logic [IDX_BITS_W-1:0] va_index_bits;
    logic                  enable_reg;
    logic [ADDR_W-1:0]     root_reg;
    fltw_result_t          expected_results[$];
    int                    errors;

    initial begin
        mismatch_count = 0;
        results_due    = 0;
        errors         = 0;
    end

    function automatic fltw_result_t final_result(input fltw_status_t st,
                                                  input logic [ADDR_W-1:0] pa);
        fltw_result_t r;
        r.kind      = KIND_FINAL;
        r.read_addr = '0;
        r.status    = st;
        r.phys_addr = pa;
        return r;
    endfunction

    function automatic fltw_result_t read_result(input logic [ADDR_W-1:0] table_base,
                                                 input logic [1:0] lvl);
        fltw_result_t r;
        r.kind      = KIND_READ;
        r.read_addr = {table_base[ADDR_W-1:12], va_index_bits[9*lvl +: INDEX_W], 3'b000};
        r.status    = ST_MAPPED;
        r.phys_addr = '0;
        return r;
    endfunction

    function automatic logic canonical_page(input logic [DATA_W-1:0] va);
        return (va[11:0] == 12'h000) && (va[63:48] == {16{va[47]}});
    endfunction

    function automatic fltw_result_t next_walk_result(input logic cmd,
                                                      input logic [DATA_W-1:0] va,
                                                      input logic [DATA_W-1:0] ev);
        fltw_result_t r;
        if (cmd == CMD_REQUEST) begin
            if (walking) begin
                r = final_result(ST_UNEXPECTED, '0);
            end else if (!enable_reg || !canonical_page(va)) begin
                r = final_result(ST_FAULT, '0);
            end else begin
                va_index_bits = va[47:12];
                walk_lvl      = LEVEL_TOP;
                walking       = 1'b1;
                r = read_result(root_reg, LEVEL_TOP);
            end
        end else if (!walking) begin
            r = final_result(ST_UNEXPECTED, '0);
        end else if (!ev[BIT_PRESENT]) begin
            walking  = 1'b0;
            walk_lvl = LEVEL_TOP;
            r = final_result((ev == '0) ? ST_UNMAPPED : ST_FAULT, '0);
        end else if ((walk_lvl == LEVEL_DIR || walk_lvl == LEVEL_MID) && ev[BIT_LARGE]) begin
            walking  = 1'b0;
            walk_lvl = LEVEL_TOP;
            r = final_result(ST_FAULT, '0);
        end else if (walk_lvl == LEVEL_LEAF) begin
            walking  = 1'b0;
            walk_lvl = LEVEL_TOP;
            r = final_result(ST_MAPPED, {ev[ADDR_W-1:12], 12'h000});
        end else begin
            walk_lvl = walk_lvl - 2'd1;
            r = read_result(ev[ADDR_W-1:0], walk_lvl);
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        fltw_result_t want;
        fltw_result_t got;
        if (!aresetn) begin
            walking       = 1'b0;
            walk_lvl      = LEVEL_TOP;
            va_index_bits = '0;
            enable_reg    = 1'b0;
            root_reg      = '0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IDX_ENABLE: enable_reg = cfg_data[0];
                    CFG_IDX_ROOT:   root_reg   = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got.kind      = m_kind;
                got.read_addr = m_read_addr;
                got.status    = fltw_status_t'(m_status);
                got.phys_addr = m_phys_addr;
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result transfer with none pending:", $realtime,
                                 " kind %0d read %h status %0d phys %h",
                                 got.kind, got.read_addr, got.status, got.phys_addr);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind != want.kind || got.read_addr != want.read_addr ||
                        got.status != want.status || got.phys_addr != want.phys_addr) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch (exp/act)", $realtime,
                                     " kind %0d/%0d read %h/%h", want.kind, got.kind,
                                     want.read_addr, got.read_addr,
                                     " status %0d/%0d phys %h/%h", want.status, got.status,
                                     want.phys_addr, got.phys_addr);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(next_walk_result(s_cmd, s_virt_addr, s_pte));
        end
        mismatch_count <= errors;
        results_due    <= expected_results.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Top of the page table walker testbench: clock, reset, stimulus and verdict.
// Depends on fltw_pkg, the walker RTL and fltw_translation_checker.

module tb;
    import fltw_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD_AT  = 150;
    localparam int LONG_HOLD     = 400;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_cmd;
    logic [DATA_W-1:0]    s_virt_addr;
    logic [DATA_W-1:0]    s_pte;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_kind;
    logic [ADDR_W-1:0]    m_read_addr;
    logic [1:0]           m_status;
    logic [ADDR_W-1:0]    m_phys_addr;
    int                   mismatch_count;
    int                   results_due;
    int                   cycle_count;
    int                   items_sent;
    bit                   send_calm;

    four_level_page_table_walker i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_virt_addr   (s_virt_addr),
        .s_pte         (s_pte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_read_addr   (m_read_addr),
        .m_status      (m_status),
        .m_phys_addr   (m_phys_addr)
    );

    fltw_translation_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_virt_addr    (s_virt_addr),
        .s_pte          (s_pte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_read_addr    (m_read_addr),
        .m_status       (m_status),
        .m_phys_addr    (m_phys_addr),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [DATA_W-1:0] v;
        v = rand64();
        return v[ADDR_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] walk_va();
        logic [DATA_W-1:0] v;
        v        = rand64();
        v[11:0]  = 12'h000;
        v[63:48] = {16{v[47]}};
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] bad_va();
        logic [DATA_W-1:0] v;
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            return rand64();
        v = walk_va();
        if (r == 1)
            v[$urandom_range(0, 11)] = 1'b1;
        else
            v[$urandom_range(48, 63)] = ~v[47];
        return v;
    endfunction

    task automatic send_item(input logic cmd, input logic [DATA_W-1:0] va,
                             input logic [DATA_W-1:0] ev);
        int g;
        if (items_sent % 64 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
        g = pick_gap(send_calm);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_virt_addr <= va;
        s_pte       <= ev;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_phase(input logic en, input logic [ADDR_W-1:0] root);
        logic [DATA_W-1:0] d;
        wait_idle();
        d    = rand64();
        d[0] = en;
        write_reg(CFG_IDX_ENABLE, d[ADDR_W-1:0]);
        write_reg(CFG_IDX_ROOT, root);
        d = rand64();
        write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_ROOT + 1, 255)), d[ADDR_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_walk();
        logic [DATA_W-1:0] ev;
        int  lv;
        int  r;
        bit  done;
        send_item(CMD_REQUEST, walk_va(), rand64());
        done = 1'b0;
        lv   = 3;
        while (!done) begin
            if ($urandom_range(0, 19) == 0)
                send_item(CMD_REQUEST, walk_va(), rand64());
            ev = rand64();
            r  = $urandom_range(0, 99);
            if (r < 4) begin
                ev = '0;
            end else if (r < 9) begin
                ev[BIT_PRESENT] = 1'b0;
            end else begin
                ev[BIT_PRESENT] = 1'b1;
                if (lv == LEVEL_DIR || lv == LEVEL_MID)
                    ev[BIT_LARGE] = (r < 16);
            end
            done = !ev[BIT_PRESENT] || lv == LEVEL_LEAF ||
                   ((lv == LEVEL_DIR || lv == LEVEL_MID) && ev[BIT_LARGE]);
            send_item(CMD_ENTRY, rand64(), ev);
            lv--;
        end
    endtask

    task automatic random_items(input int count);
        int target;
        int r;
        target = items_sent + count;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                run_walk();
            else if (r < 88)
                send_item(CMD_REQUEST, bad_va(), rand64());
            else if (r < 96)
                send_item(CMD_ENTRY, rand64(), rand64());
            else
                send_item(CMD_REQUEST, walk_va(), rand64());
        end
    endtask

    // Result side: random stalls, one long hold-off after LONG_HOLD_AT results are taken.
    initial begin
        int g;
        int taken;
        bit calm;
        m_ready <= 1'b0;
        taken = 0;
        calm  = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (taken == LONG_HOLD_AT)
                g = LONG_HOLD;
            else
                g = pick_gap(calm);
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
            if (taken % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        items_sent   = 0;
        send_calm    = 1'b0;
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        s_valid     <= 1'b0;
        s_cmd       <= CMD_REQUEST;
        s_virt_addr <= '0;
        s_pte       <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Walker disabled out of reset, entry with no walk.
        send_item(CMD_REQUEST, 64'h0000_0000_0000_0000, 64'h0);
        send_item(CMD_ENTRY, 64'h0, 64'h0000_0000_0000_1001);

        set_phase(1'b1, {ADDR_W{1'b1}});
        send_item(CMD_REQUEST, 64'h0000_0000_0000_0000, 64'h0);
        send_item(CMD_ENTRY, 64'h0, 64'h0000_0000_0000_0000);
        send_item(CMD_REQUEST, 64'hffff_ffff_ffff_f000, 64'h0);
        send_item(CMD_REQUEST, 64'h0000_0000_0000_0000, 64'h0);
        send_item(CMD_ENTRY, 64'h0, 64'hffff_ffff_ffff_ffff);
        send_item(CMD_ENTRY, 64'h0, 64'h0000_0000_0000_0081);
        send_item(CMD_REQUEST, 64'h0000_7fff_ffff_f000, 64'h0);
        send_item(CMD_ENTRY, 64'h0, 64'h0000_0000_0000_0001);
        send_item(CMD_ENTRY, 64'h0, 64'h0000_0000_0000_0001);
        send_item(CMD_ENTRY, 64'h0, 64'h0000_0000_0000_0001);
        send_item(CMD_ENTRY, 64'h0, 64'hffff_ffff_ffff_ffff);
        send_item(CMD_REQUEST, 64'h0000_0000_0000_1001, 64'h0);
        send_item(CMD_REQUEST, 64'h0000_8000_0000_0000, 64'h0);
        send_item(CMD_REQUEST, 64'hffff_7fff_ffff_f000, 64'h0);
        send_item(CMD_REQUEST, 64'h0000_0000_0000_0000, 64'h0);
        send_item(CMD_ENTRY, 64'h0, 64'hffff_ffff_ffff_fffe);
        send_item(CMD_REQUEST, 64'hffff_8000_0000_0000, 64'h0);
        send_item(CMD_ENTRY, 64'h0, 64'h0000_0000_0000_0081);
        send_item(CMD_ENTRY, 64'h0, 64'h0000_0000_0000_0001);
        send_item(CMD_ENTRY, 64'h0, 64'h0000_0000_0000_0081);

        set_phase(1'b1, rand_addr());
        random_items(300);
        set_phase(1'b0, rand_addr());
        random_items(60);
        set_phase(1'b1, '0);
        random_items(250);
        set_phase(1'b1, {ADDR_W{1'b1}});
        random_items(240);

        wait_idle();
        if (mismatch_count == 0 && results_due == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/fltw_pkg.sv
hw/rtl/fltw_cfg_regs.sv
hw/rtl/fltw_in_stage.sv
hw/rtl/fltw_walk_core.sv
hw/rtl/fltw_out_stage.sv
hw/rtl/four_level_page_table_walker.sv
hw/rtl/fltw_checker.sv
tb/fltw_translation_checker.sv
tb/tb.sv
